@@ sv/rvdec_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rvdec_pkg
// Shared types and encodings for the RV32IM subset instruction decoder.
// ----------------------------------------------------------------------------
package rvdec_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned IMM_W  = 21;
	localparam int unsigned OUT_W  = 48;

	localparam logic [6:0] OPC_OP     = 7'h33;
	localparam logic [6:0] OPC_LOAD   = 7'h03;
	localparam logic [6:0] OPC_OP_IMM = 7'h13;
	localparam logic [6:0] OPC_SYSTEM = 7'h73;
	localparam logic [6:0] OPC_STORE  = 7'h23;
	localparam logic [6:0] OPC_BRANCH = 7'h63;
	localparam logic [6:0] OPC_LUI    = 7'h37;
	localparam logic [6:0] OPC_JAL    = 7'h6f;

	localparam logic [6:0] F7_BASE   = 7'h00;
	localparam logic [6:0] F7_ALT    = 7'h20;
	localparam logic [6:0] F7_MULDIV = 7'h01;

	localparam logic [2:0] F3_ADD = 3'd0;
	localparam logic [2:0] F3_SLL = 3'd1;
	localparam logic [2:0] F3_SLT = 3'd2;
	localparam logic [2:0] F3_XOR = 3'd4;
	localparam logic [2:0] F3_SRL = 3'd5;
	localparam logic [2:0] F3_OR  = 3'd6;
	localparam logic [2:0] F3_AND = 3'd7;

	localparam logic [2:0] F3_BYTE = 3'd0;
	localparam logic [2:0] F3_HALF = 3'd1;
	localparam logic [2:0] F3_WORD = 3'd2;

	localparam logic [2:0] F3_BEQ = 3'd0;
	localparam logic [2:0] F3_BNE = 3'd1;

	localparam logic [WORD_W-1:0] ECALL_WORD = 32'h0000_0073;

	typedef enum logic [4:0] {
		OP_ADD   = 5'd0,
		OP_MUL   = 5'd1,
		OP_SUB   = 5'd2,
		OP_SLL   = 5'd3,
		OP_MULH  = 5'd4,
		OP_SLT   = 5'd5,
		OP_XOR   = 5'd6,
		OP_DIV   = 5'd7,
		OP_SRL   = 5'd8,
		OP_SRA   = 5'd9,
		OP_OR    = 5'd10,
		OP_REM   = 5'd11,
		OP_AND   = 5'd12,
		OP_ADDI  = 5'd13,
		OP_SLLI  = 5'd14,
		OP_SLTI  = 5'd15,
		OP_XORI  = 5'd16,
		OP_SRLI  = 5'd17,
		OP_SRAI  = 5'd18,
		OP_ORI   = 5'd19,
		OP_ANDI  = 5'd20,
		OP_LB    = 5'd21,
		OP_LH    = 5'd22,
		OP_LW    = 5'd23,
		OP_SB    = 5'd24,
		OP_SH    = 5'd25,
		OP_SW    = 5'd26,
		OP_BEQ   = 5'd27,
		OP_BNE   = 5'd28,
		OP_LUI   = 5'd29,
		OP_JAL   = 5'd30,
		OP_ECALL = 5'd31
	} op_t;

	typedef enum logic [2:0] {
		FMT_R      = 3'd0,
		FMT_IALU   = 3'd1,
		FMT_LOAD   = 3'd2,
		FMT_STORE  = 3'd3,
		FMT_BRANCH = 3'd4,
		FMT_LUI    = 3'd5,
		FMT_JAL    = 3'd6,
		FMT_ECALL  = 3'd7
	} fmt_t;

	typedef struct packed {
		logic        ok;
		op_t         op;
		fmt_t        fmt;
	} dec_t;

	typedef struct packed {
		logic signed [IMM_W-1:0] imm;
		logic [4:0]              rs2;
		logic [4:0]              rs1;
		logic [4:0]              rd;
		fmt_t                    fmt;
		op_t                     op;
		logic                    ok;
	} res_t;

endpackage
`default_nettype wire

@@ sv/rvdec_opdecode.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rvdec_opdecode
// Second stage: classifies the opcode and function fields into an operation
// number, a format and a supported flag; carries the word along.
// ----------------------------------------------------------------------------
module rvdec_opdecode (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               in_valid,
	input  wire                               advance,
	input  wire [rvdec_pkg::WORD_W-1:0]       word_s1,
	output logic                              valid_s2,
	output logic [rvdec_pkg::WORD_W-1:0]      word_s2,
	output rvdec_pkg::dec_t                   dec_s2
);

	logic [6:0]      opc;
	logic [2:0]      f3;
	logic [6:0]      f7;
	rvdec_pkg::dec_t dec;

	assign opc = word_s1[6:0];
	assign f3  = word_s1[14:12];
	assign f7  = word_s1[31:25];

	always_comb begin
		dec.ok  = 1'b0;
		dec.op  = rvdec_pkg::OP_ADD;
		dec.fmt = rvdec_pkg::FMT_R;
		case (opc)
			rvdec_pkg::OPC_OP: begin
				dec.fmt = rvdec_pkg::FMT_R;
				case (f3)
					rvdec_pkg::F3_ADD: begin
						if (f7 == rvdec_pkg::F7_BASE) begin
							dec.ok = 1'b1; dec.op = rvdec_pkg::OP_ADD;
						end else if (f7 == rvdec_pkg::F7_MULDIV) begin
							dec.ok = 1'b1; dec.op = rvdec_pkg::OP_MUL;
						end else if (f7 == rvdec_pkg::F7_ALT) begin
							dec.ok = 1'b1; dec.op = rvdec_pkg::OP_SUB;
						end
					end
					rvdec_pkg::F3_SLL: begin
						if (f7 == rvdec_pkg::F7_BASE) begin
							dec.ok = 1'b1; dec.op = rvdec_pkg::OP_SLL;
						end else if (f7 == rvdec_pkg::F7_MULDIV) begin
							dec.ok = 1'b1; dec.op = rvdec_pkg::OP_MULH;
						end
					end
					rvdec_pkg::F3_SLT: begin
						if (f7 == rvdec_pkg::F7_BASE) begin
							dec.ok = 1'b1; dec.op = rvdec_pkg::OP_SLT;
						end
					end
					rvdec_pkg::F3_XOR: begin
						if (f7 == rvdec_pkg::F7_BASE) begin
							dec.ok = 1'b1; dec.op = rvdec_pkg::OP_XOR;
						end else if (f7 == rvdec_pkg::F7_MULDIV) begin
							dec.ok = 1'b1; dec.op = rvdec_pkg::OP_DIV;
						end
					end
					rvdec_pkg::F3_SRL: begin
						if (f7 == rvdec_pkg::F7_BASE) begin
							dec.ok = 1'b1; dec.op = rvdec_pkg::OP_SRL;
						end else if (f7 == rvdec_pkg::F7_ALT) begin
							dec.ok = 1'b1; dec.op = rvdec_pkg::OP_SRA;
						end
					end
					rvdec_pkg::F3_OR: begin
						if (f7 == rvdec_pkg::F7_BASE) begin
							dec.ok = 1'b1; dec.op = rvdec_pkg::OP_OR;
						end else if (f7 == rvdec_pkg::F7_MULDIV) begin
							dec.ok = 1'b1; dec.op = rvdec_pkg::OP_REM;
						end
					end
					rvdec_pkg::F3_AND: begin
						if (f7 == rvdec_pkg::F7_BASE) begin
							dec.ok = 1'b1; dec.op = rvdec_pkg::OP_AND;
						end
					end
					default: dec.ok = 1'b0;
				endcase
			end
			rvdec_pkg::OPC_OP_IMM: begin
				dec.fmt = rvdec_pkg::FMT_IALU;
				case (f3)
					rvdec_pkg::F3_ADD: begin
						dec.ok = 1'b1; dec.op = rvdec_pkg::OP_ADDI;
					end
					rvdec_pkg::F3_SLL: begin
						if (f7 == rvdec_pkg::F7_BASE) begin
							dec.ok = 1'b1; dec.op = rvdec_pkg::OP_SLLI;
						end
					end
					rvdec_pkg::F3_SLT: begin
						dec.ok = 1'b1; dec.op = rvdec_pkg::OP_SLTI;
					end
					rvdec_pkg::F3_XOR: begin
						dec.ok = 1'b1; dec.op = rvdec_pkg::OP_XORI;
					end
					rvdec_pkg::F3_SRL: begin
						if (f7 == rvdec_pkg::F7_BASE) begin
							dec.ok = 1'b1; dec.op = rvdec_pkg::OP_SRLI;
						end else if (f7 == rvdec_pkg::F7_ALT) begin
							dec.ok = 1'b1; dec.op = rvdec_pkg::OP_SRAI;
						end
					end
					rvdec_pkg::F3_OR: begin
						dec.ok = 1'b1; dec.op = rvdec_pkg::OP_ORI;
					end
					rvdec_pkg::F3_AND: begin
						dec.ok = 1'b1; dec.op = rvdec_pkg::OP_ANDI;
					end
					default: dec.ok = 1'b0;
				endcase
			end
			rvdec_pkg::OPC_LOAD: begin
				dec.fmt = rvdec_pkg::FMT_LOAD;
				case (f3)
					rvdec_pkg::F3_BYTE: begin
						dec.ok = 1'b1; dec.op = rvdec_pkg::OP_LB;
					end
					rvdec_pkg::F3_HALF: begin
						dec.ok = 1'b1; dec.op = rvdec_pkg::OP_LH;
					end
					rvdec_pkg::F3_WORD: begin
						dec.ok = 1'b1; dec.op = rvdec_pkg::OP_LW;
					end
					default: dec.ok = 1'b0;
				endcase
			end
			rvdec_pkg::OPC_STORE: begin
				dec.fmt = rvdec_pkg::FMT_STORE;
				case (f3)
					rvdec_pkg::F3_BYTE: begin
						dec.ok = 1'b1; dec.op = rvdec_pkg::OP_SB;
					end
					rvdec_pkg::F3_HALF: begin
						dec.ok = 1'b1; dec.op = rvdec_pkg::OP_SH;
					end
					rvdec_pkg::F3_WORD: begin
						dec.ok = 1'b1; dec.op = rvdec_pkg::OP_SW;
					end
					default: dec.ok = 1'b0;
				endcase
			end
			rvdec_pkg::OPC_BRANCH: begin
				dec.fmt = rvdec_pkg::FMT_BRANCH;
				case (f3)
					rvdec_pkg::F3_BEQ: begin
						dec.ok = 1'b1; dec.op = rvdec_pkg::OP_BEQ;
					end
					rvdec_pkg::F3_BNE: begin
						dec.ok = 1'b1; dec.op = rvdec_pkg::OP_BNE;
					end
					default: dec.ok = 1'b0;
				endcase
			end
			rvdec_pkg::OPC_LUI: begin
				dec.ok  = 1'b1;
				dec.op  = rvdec_pkg::OP_LUI;
				dec.fmt = rvdec_pkg::FMT_LUI;
			end
			rvdec_pkg::OPC_JAL: begin
				dec.ok  = 1'b1;
				dec.op  = rvdec_pkg::OP_JAL;
				dec.fmt = rvdec_pkg::FMT_JAL;
			end
			rvdec_pkg::OPC_SYSTEM: begin
				dec.ok  = (word_s1 == rvdec_pkg::ECALL_WORD);
				dec.op  = rvdec_pkg::OP_ECALL;
				dec.fmt = rvdec_pkg::FMT_ECALL;
			end
			default: dec.ok = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			word_s2 <= word_s1;
			dec_s2  <= dec;
		end
	end

endmodule
`default_nettype wire

@@ sv/rvdec_fieldsel.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rvdec_fieldsel
// Third stage: builds the immediate for the decoded format, zeroes the
// register numbers a format does not use and clears invalid results.
// ----------------------------------------------------------------------------
module rvdec_fieldsel (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               in_valid,
	input  wire                               advance,
	input  wire [rvdec_pkg::WORD_W-1:0]       word_s2,
	input  rvdec_pkg::dec_t                   dec_s2,
	output logic                              valid_s3,
	output rvdec_pkg::res_t                   res_s3
);

	logic [rvdec_pkg::WORD_W-1:0] w;
	rvdec_pkg::res_t              res;
	logic                         use_rd;
	logic                         use_rs1;
	logic                         use_rs2;

	assign w = word_s2;

	always_comb begin
		use_rd  = 1'b0;
		use_rs1 = 1'b0;
		use_rs2 = 1'b0;
		res.imm = '0;
		case (dec_s2.fmt)
			rvdec_pkg::FMT_R: begin
				use_rd = 1'b1; use_rs1 = 1'b1; use_rs2 = 1'b1;
			end
			rvdec_pkg::FMT_IALU: begin
				use_rd = 1'b1; use_rs1 = 1'b1;
				if (dec_s2.op == rvdec_pkg::OP_SLLI || dec_s2.op == rvdec_pkg::OP_SRLI ||
					dec_s2.op == rvdec_pkg::OP_SRAI) begin
					res.imm = {16'b0, w[24:20]};
				end else begin
					res.imm = {{9{w[31]}}, w[31:20]};
				end
			end
			rvdec_pkg::FMT_LOAD: begin
				use_rd = 1'b1; use_rs1 = 1'b1;
				res.imm = {{9{w[31]}}, w[31:20]};
			end
			rvdec_pkg::FMT_STORE: begin
				use_rs1 = 1'b1; use_rs2 = 1'b1;
				res.imm = {{9{w[31]}}, w[31:25], w[11:7]};
			end
			rvdec_pkg::FMT_BRANCH: begin
				use_rs1 = 1'b1; use_rs2 = 1'b1;
				res.imm = {{8{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
			end
			rvdec_pkg::FMT_LUI: begin
				use_rd = 1'b1;
				res.imm = {1'b0, w[31:12]};
			end
			rvdec_pkg::FMT_JAL: begin
				use_rd = 1'b1;
				res.imm = {w[31], w[19:12], w[20], w[30:21], 1'b0};
			end
			default: res.imm = '0;
		endcase

		res.ok  = dec_s2.ok;
		res.op  = dec_s2.op;
		res.fmt = dec_s2.fmt;
		res.rd  = use_rd  ? w[11:7]  : 5'd0;
		res.rs1 = use_rs1 ? w[19:15] : 5'd0;
		res.rs2 = use_rs2 ? w[24:20] : 5'd0;

		// unsupported words report all-zero fields
		if (!dec_s2.ok) begin
			res = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s3 <= res;
		end
	end

endmodule
`default_nettype wire

@@ sv/rv32im_subset_instruction_decoder_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rv32im_subset_instruction_decoder_top
// Decodes RV32IM subset instruction words into operation, format, register
// numbers and immediate, one word per clock while the output is not stalled.
//
// Input channel s_axis_*: one 32-bit instruction word per transfer.
// Output channel m_axis_*: one decoded word per input word, in order.
// m_axis_tvalid rises once the word has passed through every stage in order:
// stage one registers the word, stage two classifies opcode and function
// fields, stage three builds the immediate and register fields and holds the
// result on the output.
// Throughput is one word per cycle while m_axis_tready is high; every stage
// has a valid bit and moves whenever the stage after it is empty or moving.
// When m_axis_tready is low the result holds, the pipeline fills and
// s_axis_tready falls once every stage holds a word; nothing is dropped or
// repeated. Reset empties all stages; no word is presented after reset until
// a new one has been accepted.
// ----------------------------------------------------------------------------
module rv32im_subset_instruction_decoder_top (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               s_axis_tvalid,
	output logic                              s_axis_tready,
	// [31:0] instr_word
	input  wire [rvdec_pkg::WORD_W-1:0]       s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  wire                               m_axis_tready,
	// [0] valid_res, [5:1] op_id, [8:6] fmt, [13:9] rd, [18:14] rs1,
	// [23:19] rs2, [44:24] imm, [47:45] zero
	output logic [rvdec_pkg::OUT_W-1:0]       m_axis_tdata
);

	logic                         valid_s1;
	logic [rvdec_pkg::WORD_W-1:0] word_s1;
	logic                         valid_s2;
	logic [rvdec_pkg::WORD_W-1:0] word_s2;
	rvdec_pkg::dec_t              dec_s2;
	logic                         valid_s3;
	rvdec_pkg::res_t              res_s3;
	logic                         adv1;
	logic                         adv2;
	logic                         adv3;

	assign adv3 = !valid_s3 || m_axis_tready;
	assign adv2 = !valid_s2 || adv3;
	assign adv1 = !valid_s1 || adv2;

	assign s_axis_tready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv1) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			word_s1 <= s_axis_tdata;
		end
	end

	rvdec_opdecode u_opdecode (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s1),
		.advance  (adv2),
		.word_s1  (word_s1),
		.valid_s2 (valid_s2),
		.word_s2  (word_s2),
		.dec_s2   (dec_s2)
	);

	rvdec_fieldsel u_fieldsel (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s2),
		.advance  (adv3),
		.word_s2  (word_s2),
		.dec_s2   (dec_s2),
		.valid_s3 (valid_s3),
		.res_s3   (res_s3)
	);

	assign m_axis_tvalid = valid_s3;
	assign m_axis_tdata  = {3'b000, res_s3.imm, res_s3.rs2, res_s3.rs1, res_s3.rd,
		res_s3.fmt, res_s3.op, res_s3.ok};

endmodule
`default_nettype wire

@@ tb/sv/rvdec_tb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvdec_tb_pkg
// Decode predictor and scoreboard for the RV32IM subset decoder bench. Each
// accepted instruction word is decoded here and queued; each decoded word from
// the block is checked field by field against the oldest queued entry.
// ----------------------------------------------------------------------------
package rvdec_tb_pkg;

	import rvdec_pkg::*;

	function automatic res_t decode_word(input logic [WORD_W-1:0] w);
		res_t             r;
		logic [6:0]       opc;
		logic [6:0]       f7;
		logic [2:0]       f3;
		logic [IMM_W-1:0] imm_i;
		logic             ok;
		opc   = w[6:0];
		f3    = w[14:12];
		f7    = w[31:25];
		imm_i = {{9{w[31]}}, w[31:20]};
		r     = '0;
		ok    = 1'b1;
		r.ok  = 1'b1;
		r.rd  = w[11:7];
		r.rs1 = w[19:15];
		r.rs2 = w[24:20];
		case (opc)
			OPC_OP: begin
				r.fmt = FMT_R;
				case (f3)
					F3_ADD: begin
						if (f7 == F7_BASE) r.op = OP_ADD;
						else if (f7 == F7_MULDIV) r.op = OP_MUL;
						else if (f7 == F7_ALT) r.op = OP_SUB;
						else ok = 1'b0;
					end
					F3_SLL: begin
						if (f7 == F7_BASE) r.op = OP_SLL;
						else if (f7 == F7_MULDIV) r.op = OP_MULH;
						else ok = 1'b0;
					end
					F3_SLT: begin
						if (f7 == F7_BASE) r.op = OP_SLT;
						else ok = 1'b0;
					end
					F3_XOR: begin
						if (f7 == F7_BASE) r.op = OP_XOR;
						else if (f7 == F7_MULDIV) r.op = OP_DIV;
						else ok = 1'b0;
					end
					F3_SRL: begin
						if (f7 == F7_BASE) r.op = OP_SRL;
						else if (f7 == F7_ALT) r.op = OP_SRA;
						else ok = 1'b0;
					end
					F3_OR: begin
						if (f7 == F7_BASE) r.op = OP_OR;
						else if (f7 == F7_MULDIV) r.op = OP_REM;
						else ok = 1'b0;
					end
					F3_AND: begin
						if (f7 == F7_BASE) r.op = OP_AND;
						else ok = 1'b0;
					end
					default: ok = 1'b0;
				endcase
			end
			OPC_OP_IMM: begin
				r.fmt = FMT_IALU;
				r.rs2 = '0;
				r.imm = imm_i;
				case (f3)
					F3_ADD: r.op = OP_ADDI;
					F3_SLL: begin
						r.op  = OP_SLLI;
						r.imm = {16'b0, w[24:20]};
						ok    = (f7 == F7_BASE);
					end
					F3_SLT: r.op = OP_SLTI;
					F3_XOR: r.op = OP_XORI;
					F3_SRL: begin
						r.imm = {16'b0, w[24:20]};
						if (f7 == F7_BASE) r.op = OP_SRLI;
						else if (f7 == F7_ALT) r.op = OP_SRAI;
						else ok = 1'b0;
					end
					F3_OR:  r.op = OP_ORI;
					F3_AND: r.op = OP_ANDI;
					default: ok = 1'b0;
				endcase
			end
			OPC_LOAD: begin
				r.fmt = FMT_LOAD;
				r.rs2 = '0;
				r.imm = imm_i;
				case (f3)
					F3_BYTE: r.op = OP_LB;
					F3_HALF: r.op = OP_LH;
					F3_WORD: r.op = OP_LW;
					default: ok = 1'b0;
				endcase
			end
			OPC_STORE: begin
				r.fmt = FMT_STORE;
				r.rd  = '0;
				r.imm = {{9{w[31]}}, w[31:25], w[11:7]};
				case (f3)
					F3_BYTE: r.op = OP_SB;
					F3_HALF: r.op = OP_SH;
					F3_WORD: r.op = OP_SW;
					default: ok = 1'b0;
				endcase
			end
			OPC_BRANCH: begin
				r.fmt = FMT_BRANCH;
				r.rd  = '0;
				r.imm = {{8{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
				case (f3)
					F3_BEQ: r.op = OP_BEQ;
					F3_BNE: r.op = OP_BNE;
					default: ok = 1'b0;
				endcase
			end
			OPC_LUI: begin
				r.fmt = FMT_LUI;
				r.op  = OP_LUI;
				r.rs1 = '0;
				r.rs2 = '0;
				r.imm = {1'b0, w[31:12]};
			end
			OPC_JAL: begin
				r.fmt = FMT_JAL;
				r.op  = OP_JAL;
				r.rs1 = '0;
				r.rs2 = '0;
				r.imm = {w[31], w[19:12], w[20], w[30:21], 1'b0};
			end
			OPC_SYSTEM: begin
				r.fmt = FMT_ECALL;
				r.op  = OP_ECALL;
				r.rd  = '0;
				r.rs1 = '0;
				r.rs2 = '0;
				ok    = (w == ECALL_WORD);
			end
			default: ok = 1'b0;
		endcase
		if (!ok) r = '0;
		return r;
	endfunction

	class decode_scoreboard;
		res_t        expected_q[$];
		int unsigned errors;

		function new();
			errors = 0;
		endfunction

		function void note_word(input logic [WORD_W-1:0] w);
			expected_q.push_back(decode_word(w));
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		function void compare_field(input string name, input int exp_v, input int act_v);
			if (exp_v != act_v) begin
				$error("%s: expected %0d, got %0d", name, exp_v, act_v);
				errors++;
			end
		endfunction

		function void check_result(input logic [OUT_W-1:0] d);
			res_t got;
			res_t want;
			got = res_t'(d[$bits(res_t)-1:0]);
			if (expected_q.size() == 0) begin
				$error("decoded word %h with nothing expected", d);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			compare_field("valid_res", int'(want.ok), int'(got.ok));
			compare_field("op_id", int'(want.op), int'(got.op));
			compare_field("fmt", int'(want.fmt), int'(got.fmt));
			compare_field("rd", int'(want.rd), int'(got.rd));
			compare_field("rs1", int'(want.rs1), int'(got.rs1));
			compare_field("rs2", int'(want.rs2), int'(got.rs2));
			compare_field("imm", int'(want.imm), int'(got.imm));
			compare_field("pad", 0, int'(d[OUT_W-1:$bits(res_t)]));
		endfunction
	endclass

endpackage

@@ tb/sv/tb_rv32im_subset_instruction_decoder_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rv32im_subset_instruction_decoder_top
// Stream bench for the RV32IM subset decoder. A directed set of boundary and
// corner encodings is followed by mostly well-formed random instructions,
// with corrupted function fields, system-opcode noise and fully random words
// mixed in. Both stream sides stall in random bursts; results are checked
// in order against a decode predictor.
// ----------------------------------------------------------------------------
module tb_rv32im_subset_instruction_decoder_top;

	import rvdec_pkg::*;
	import rvdec_tb_pkg::*;

	localparam int unsigned N_RANDOM = 600;
	localparam int unsigned N_QUIET  = 80;

	logic                clk;
	logic                arst_n;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [WORD_W-1:0]   s_axis_tdata;
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [OUT_W-1:0]    m_axis_tdata;

	bit                  quiet = 1'b0;
	decode_scoreboard    sb = new();

	rv32im_subset_instruction_decoder_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("tb_rv32im_subset_instruction_decoder_top: done, errors");
		$finish;
	end

	// result side back-pressure
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			if (!quiet && $urandom_range(0, 2) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
	end

	function automatic logic [WORD_W-1:0] random_word();
		logic [WORD_W-1:0] w;
		logic [6:0]        opc;
		logic [6:0]        f7;
		logic [2:0]        f3;
		op_t               op;
		int unsigned       sel;
		w   = $urandom;
		sel = $urandom_range(0, 99);
		op  = op_t'(5'($urandom_range(0, 31)));
		opc = w[6:0];
		f3  = w[14:12];
		f7  = w[31:25];
		if (sel >= 92) return w;
		if (sel >= 87) begin
			w[6:0] = OPC_SYSTEM;
			return w;
		end
		case (op)
			OP_ADD:   begin opc = OPC_OP; f3 = F3_ADD; f7 = F7_BASE; end
			OP_MUL:   begin opc = OPC_OP; f3 = F3_ADD; f7 = F7_MULDIV; end
			OP_SUB:   begin opc = OPC_OP; f3 = F3_ADD; f7 = F7_ALT; end
			OP_SLL:   begin opc = OPC_OP; f3 = F3_SLL; f7 = F7_BASE; end
			OP_MULH:  begin opc = OPC_OP; f3 = F3_SLL; f7 = F7_MULDIV; end
			OP_SLT:   begin opc = OPC_OP; f3 = F3_SLT; f7 = F7_BASE; end
			OP_XOR:   begin opc = OPC_OP; f3 = F3_XOR; f7 = F7_BASE; end
			OP_DIV:   begin opc = OPC_OP; f3 = F3_XOR; f7 = F7_MULDIV; end
			OP_SRL:   begin opc = OPC_OP; f3 = F3_SRL; f7 = F7_BASE; end
			OP_SRA:   begin opc = OPC_OP; f3 = F3_SRL; f7 = F7_ALT; end
			OP_OR:    begin opc = OPC_OP; f3 = F3_OR; f7 = F7_BASE; end
			OP_REM:   begin opc = OPC_OP; f3 = F3_OR; f7 = F7_MULDIV; end
			OP_AND:   begin opc = OPC_OP; f3 = F3_AND; f7 = F7_BASE; end
			OP_ADDI:  begin opc = OPC_OP_IMM; f3 = F3_ADD; end
			OP_SLLI:  begin opc = OPC_OP_IMM; f3 = F3_SLL; f7 = F7_BASE; end
			OP_SLTI:  begin opc = OPC_OP_IMM; f3 = F3_SLT; end
			OP_XORI:  begin opc = OPC_OP_IMM; f3 = F3_XOR; end
			OP_SRLI:  begin opc = OPC_OP_IMM; f3 = F3_SRL; f7 = F7_BASE; end
			OP_SRAI:  begin opc = OPC_OP_IMM; f3 = F3_SRL; f7 = F7_ALT; end
			OP_ORI:   begin opc = OPC_OP_IMM; f3 = F3_OR; end
			OP_ANDI:  begin opc = OPC_OP_IMM; f3 = F3_AND; end
			OP_LB:    begin opc = OPC_LOAD; f3 = F3_BYTE; end
			OP_LH:    begin opc = OPC_LOAD; f3 = F3_HALF; end
			OP_LW:    begin opc = OPC_LOAD; f3 = F3_WORD; end
			OP_SB:    begin opc = OPC_STORE; f3 = F3_BYTE; end
			OP_SH:    begin opc = OPC_STORE; f3 = F3_HALF; end
			OP_SW:    begin opc = OPC_STORE; f3 = F3_WORD; end
			OP_BEQ:   begin opc = OPC_BRANCH; f3 = F3_BEQ; end
			OP_BNE:   begin opc = OPC_BRANCH; f3 = F3_BNE; end
			OP_LUI:   opc = OPC_LUI;
			OP_JAL:   opc = OPC_JAL;
			OP_ECALL: opc = OPC_SYSTEM;
		endcase
		// broken encodings: valid opcode, disturbed function field
		if (sel >= 75) begin
			if ($urandom_range(0, 1) == 1) f7 = 7'($urandom);
			else f3 = 3'($urandom);
		end
		w = {f7, w[24:15], f3, w[11:7], opc};
		if (op == OP_ECALL && sel < 75) w = ECALL_WORD;
		return w;
	endfunction

	task automatic send_word(input logic [WORD_W-1:0] w);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= w;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_word(w);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	task automatic drain_wait();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	initial begin
		logic [WORD_W-1:0] directed_words[$];
		directed_words = '{
			32'h0000_0000,
			32'hffff_ffff,
			{F7_BASE, 5'd31, 5'd31, F3_ADD, 5'd31, OPC_OP},
			{F7_MULDIV, 5'd1, 5'd2, F3_ADD, 5'd3, OPC_OP},
			{F7_ALT, 5'd0, 5'd0, F3_ADD, 5'd0, OPC_OP},
			{F7_MULDIV, 5'd5, 5'd6, F3_SLT, 5'd7, OPC_OP},
			{7'h7f, 5'd31, 5'd31, F3_AND, 5'd31, OPC_OP},
			{F7_BASE, 5'd4, 5'd4, 3'd3, 5'd4, OPC_OP},
			{F7_ALT, 5'd9, 5'd10, F3_SRL, 5'd11, OPC_OP},
			{12'h800, 5'd31, F3_ADD, 5'd1, OPC_OP_IMM},
			{12'h7ff, 5'd0, F3_ADD, 5'd31, OPC_OP_IMM},
			{F7_BASE, 5'd31, 5'd3, F3_SLL, 5'd2, OPC_OP_IMM},
			{F7_ALT, 5'd1, 5'd3, F3_SLL, 5'd2, OPC_OP_IMM},
			{F7_ALT, 5'd31, 5'd8, F3_SRL, 5'd9, OPC_OP_IMM},
			{7'h21, 5'd7, 5'd8, F3_SRL, 5'd9, OPC_OP_IMM},
			{12'hfff, 5'd5, 3'd3, 5'd6, OPC_OP_IMM},
			{12'h800, 5'd31, F3_BYTE, 5'd31, OPC_LOAD},
			{12'h7ff, 5'd1, F3_WORD, 5'd2, OPC_LOAD},
			{12'h123, 5'd1, 3'd3, 5'd2, OPC_LOAD},
			{7'h7f, 5'd31, 5'd31, F3_WORD, 5'd31, OPC_STORE},
			{7'h00, 5'd1, 5'd2, 3'd7, 5'd3, OPC_STORE},
			{1'b1, 6'h00, 5'd1, 5'd2, F3_BEQ, 4'h0, 1'b0, OPC_BRANCH},
			{1'b0, 6'h3f, 5'd31, 5'd31, F3_BNE, 4'hf, 1'b1, OPC_BRANCH},
			{7'h00, 5'd0, 5'd0, 3'd2, 5'd0, OPC_BRANCH},
			{20'hfffff, 5'd31, OPC_LUI},
			{1'b1, 10'h000, 1'b0, 8'h00, 5'd1, OPC_JAL},
			{1'b0, 10'h3ff, 1'b1, 8'hff, 5'd0, OPC_JAL},
			ECALL_WORD,
			32'h0010_0073
		};
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_words[i]) send_word(directed_words[i]);
		drain_wait();

		for (int unsigned i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM / 2) drain_wait();
			quiet = (i >= N_RANDOM - N_QUIET);
			send_word(random_word());
		end

		drain_wait();
		repeat (10) @(posedge clk);
		if (sb.errors == 0) begin
			$display("tb_rv32im_subset_instruction_decoder_top: done, clean");
		end else begin
			$display("tb_rv32im_subset_instruction_decoder_top: done, errors");
		end
		$finish;
	end

endmodule
